FILE: src/idel_pkg.sv
// ----------------------------------------------------------------------------
// idel_pkg
// Types and constants shared by the indexed double-ended list.
// ----------------------------------------------------------------------------
`default_nettype none

package idel_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int POS_W      = 5;
  localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [3:0] {
    REQ_PUSH_FRONT = 4'd0,
    REQ_PUSH_BACK  = 4'd1,
    REQ_POP_FRONT  = 4'd2,
    REQ_POP_BACK   = 4'd3,
    REQ_FRONT      = 4'd4,
    REQ_BACK       = 4'd5,
    REQ_GET        = 4'd6,
    REQ_INSERT     = 4'd7,
    REQ_ERASE      = 4'd8
  } req_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_RANGE     = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY_POP = 2'd3
  } status_e;

  typedef struct packed {
    logic [3:0]         req_type;
    logic [POS_W-1:0]   position;
    logic signed [31:0] item_value;
  } idel_req_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [4:0]         element_count;
    logic               is_empty;
    logic [1:0]         status;
  } idel_res_t;

  typedef struct packed {
    logic             ins;
    logic             del;
    logic [IDX_W-1:0] idx;
    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;
    status_e          status;
    logic [CNT_W-1:0] cnt_nxt;
  } idel_op_t;

endpackage

`default_nettype wire

FILE: src/idel_ctrl.sv
// ----------------------------------------------------------------------------
// idel_ctrl
// Request decode, range and full checks, and the element count.
// ----------------------------------------------------------------------------
`default_nettype none

module idel_ctrl import idel_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      valid_i,
  input  wire idel_req_t req_i,
  output idel_op_t       op_o
);

  logic [CNT_W-1:0] count_q, count_d;
  logic [CMP_W-1:0] pos_x, cnt_x;
  logic             empty, full;

  assign pos_x = CMP_W'(req_i.position);
  assign cnt_x = CMP_W'(count_q);
  assign empty = (count_q == '0);
  assign full  = (count_q == CNT_W'(CAPACITY));

  always_comb begin
    op_o         = '0;
    op_o.status  = ST_OK;
    op_o.cnt_nxt = count_q;
    case (req_e'(req_i.req_type))
      REQ_PUSH_FRONT: begin
        if (full) begin
          op_o.status = ST_FULL;
        end else begin
          op_o.ins     = 1'b1;
          op_o.idx     = '0;
          op_o.cnt_nxt = count_q + 1'b1;
        end
      end
      REQ_PUSH_BACK: begin
        if (full) begin
          op_o.status = ST_FULL;
        end else begin
          op_o.ins     = 1'b1;
          op_o.idx     = IDX_W'(count_q);
          op_o.cnt_nxt = count_q + 1'b1;
        end
      end
      REQ_POP_FRONT: begin
        if (empty) begin
          op_o.status = ST_EMPTY_POP;
        end else begin
          op_o.del     = 1'b1;
          op_o.idx     = '0;
          op_o.cnt_nxt = count_q - 1'b1;
        end
      end
      REQ_POP_BACK: begin
        if (empty) begin
          op_o.status = ST_EMPTY_POP;
        end else begin
          op_o.cnt_nxt = count_q - 1'b1;
        end
      end
      REQ_FRONT: begin
        if (empty) begin
          op_o.status = ST_RANGE;
        end else begin
          op_o.rd_en  = 1'b1;
          op_o.rd_idx = '0;
        end
      end
      REQ_BACK: begin
        if (empty) begin
          op_o.status = ST_RANGE;
        end else begin
          op_o.rd_en  = 1'b1;
          op_o.rd_idx = IDX_W'(count_q - 1'b1);
        end
      end
      REQ_GET: begin
        if (pos_x >= cnt_x) begin
          op_o.status = ST_RANGE;
        end else begin
          op_o.rd_en  = 1'b1;
          op_o.rd_idx = IDX_W'(pos_x);
        end
      end
      REQ_INSERT: begin
        if (pos_x > cnt_x) begin
          op_o.status = ST_RANGE;
        end else if (full) begin
          op_o.status = ST_FULL;
        end else begin
          op_o.ins     = 1'b1;
          op_o.idx     = IDX_W'(pos_x);
          op_o.cnt_nxt = count_q + 1'b1;
        end
      end
      REQ_ERASE: begin
        if (pos_x >= cnt_x) begin
          op_o.status = ST_RANGE;
        end else begin
          op_o.del     = 1'b1;
          op_o.idx     = IDX_W'(pos_x);
          op_o.cnt_nxt = count_q - 1'b1;
        end
      end
      default: begin
        op_o.status = ST_OK;
      end
    endcase
  end

  assign count_d = valid_i ? op_o.cnt_nxt : count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire

FILE: src/idel_cells.sv
// ----------------------------------------------------------------------------
// idel_cells
// Slot array: each slot holds, loads, or shifts up or down on an index compare.
// ----------------------------------------------------------------------------
`default_nettype none

module idel_cells import idel_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   valid_i,
  input  wire idel_op_t               op_i,
  input  wire logic [DATA_WIDTH-1:0]  wr_data_i,
  output logic      [DATA_WIDTH-1:0]  rd_data_o
);

  logic [DATA_WIDTH-1:0] slots_q [CAPACITY];
  logic [DATA_WIDTH-1:0] slots_d [CAPACITY];

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      slots_d[i] = slots_q[i];
      if (valid_i && op_i.ins) begin
        if (IDX_W'(i) == op_i.idx) begin
          slots_d[i] = wr_data_i;
        end else if ((i > 0) && (IDX_W'(i) > op_i.idx)) begin
          slots_d[i] = slots_q[(i > 0) ? i - 1 : 0];
        end
      end else if (valid_i && op_i.del) begin
        if ((i < CAPACITY - 1) && (IDX_W'(i) >= op_i.idx)) begin
          slots_d[i] = slots_q[(i < CAPACITY - 1) ? i + 1 : i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < CAPACITY; i++) begin
      slots_q[i] <= slots_d[i];
    end
  end

  assign rd_data_o = slots_q[op_i.rd_idx];

endmodule

`default_nettype wire

FILE: src/indexed_double_ended_list.sv
// ----------------------------------------------------------------------------
// indexed_double_ended_list
// Bounded ordered list with push, pop, indexed read, insert and erase.
// ----------------------------------------------------------------------------
// An item is taken whenever start_i is high; busy_o is always low, so one item
// can enter every clock. The item is registered in req_q, decoded and applied
// to the slot array in the following cycle; its result is registered in res_q
// and appears on res_o with done_o, registered in done_q, high for one cycle
// only. The receiver cannot stall: the result must be captured in that cycle.
// Results come out in the order items went in; each sees the list as left by
// the one before it.
`default_nettype none

module indexed_double_ended_list import idel_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start_i,
  output logic           busy_o,
  input  wire idel_req_t req_i,
  output logic           done_o,
  output idel_res_t      res_o
);

  logic                  req_valid_q;
  idel_req_t             req_q;
  idel_op_t              op;
  logic [DATA_WIDTH-1:0] rd_data;
  logic                  done_q;
  idel_res_t             res_q, res_d;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      req_valid_q <= start_i;
      done_q      <= req_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      req_q <= req_i;
    end
    res_q <= res_d;
  end

  idel_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (req_valid_q),
    .req_i   (req_q),
    .op_o    (op)
  );

  idel_cells u_cells (
    .clk_i     (clk_i),
    .valid_i   (req_valid_q),
    .op_i      (op),
    .wr_data_i (DATA_WIDTH'(req_q.item_value)),
    .rd_data_o (rd_data)
  );

  always_comb begin
    res_d.read_value    = op.rd_en ? 32'(rd_data) : '0;
    res_d.element_count = 5'(op.cnt_nxt);
    res_d.is_empty      = (op.cnt_nxt == '0);
    res_d.status        = op.status;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the indexed double-ended list against an in-bench prediction.
// ----------------------------------------------------------------------------
// A list tracker mirrors the slot array and the element count, works out the
// response for every accepted request and compares each done_o response with
// the oldest one waiting. A short directed run covers the empty, range and
// unknown-request cases. Random phases then drive the list toward full, toward
// empty or around the middle, with random idle bursts on the request side in all but two phases.
`timescale 1ns / 1ps

module testbench;
  import idel_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 100000;
  localparam int unsigned PHASE_LEN   = 200;
  localparam int unsigned PHASES      = 8;

  typedef enum int unsigned {MIX_GROW, MIX_SHRINK, MIX_EVEN} mix_e;

  class list_tracker;
    logic [DATA_WIDTH-1:0] slots [CAPACITY];
    int unsigned           count;
    idel_res_t             due_responses [$];
    int unsigned           failures;

    function new();
      count    = 0;
      failures = 0;
    endfunction

    function int unsigned outstanding();
      return due_responses.size();
    endfunction

    function void flag(string msg);
      failures++;
      if (failures <= 10) $display("mismatch: %s", msg);
    endfunction

    // later elements move up one, leaving slot pos free
    function void open_gap(int unsigned pos);
      for (int unsigned i = count; i > pos; i--) slots[i] = slots[i-1];
    endfunction

    // later elements move down one over slot pos
    function void close_gap(int unsigned pos);
      for (int unsigned i = pos; i + 1 < count; i++) slots[i] = slots[i+1];
    endfunction

    function void note_request(idel_req_t r);
      idel_res_t             resp;
      logic [DATA_WIDTH-1:0] rd;
      int unsigned           pos;
      status_e               st;
      rd  = '0;
      st  = ST_OK;
      pos = r.position;
      case (r.req_type)
        REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
          if (count >= CAPACITY) begin
            st = ST_FULL;
          end else if (r.req_type == REQ_PUSH_FRONT) begin
            open_gap(0);
            slots[0] = r.item_value;
            count++;
          end else begin
            slots[count] = r.item_value;
            count++;
          end
        end
        REQ_POP_FRONT: begin
          if (count == 0) begin
            st = ST_EMPTY_POP;
          end else begin
            close_gap(0);
            count--;
          end
        end
        REQ_POP_BACK: begin
          if (count == 0) st = ST_EMPTY_POP;
          else count--;
        end
        REQ_FRONT: begin
          if (count == 0) st = ST_RANGE;
          else rd = slots[0];
        end
        REQ_BACK: begin
          if (count == 0) st = ST_RANGE;
          else rd = slots[count-1];
        end
        REQ_GET: begin
          if (pos >= count) st = ST_RANGE;
          else rd = slots[pos];
        end
        REQ_INSERT: begin
          if (pos > count) begin
            st = ST_RANGE;
          end else if (count >= CAPACITY) begin
            st = ST_FULL;
          end else begin
            open_gap(pos);
            slots[pos] = r.item_value;
            count++;
          end
        end
        REQ_ERASE: begin
          if (pos >= count) begin
            st = ST_RANGE;
          end else begin
            close_gap(pos);
            count--;
          end
        end
        default: ;
      endcase
      resp.read_value    = rd;
      resp.element_count = count[4:0];
      resp.is_empty      = (count == 0);
      resp.status        = st;
      due_responses = {due_responses, resp};
    endfunction

    function void check_result(idel_res_t got);
      idel_res_t want;
      if (due_responses.size() == 0) begin
        flag($sformatf("response with none expected: rd=%0d cnt=%0d empty=%0b st=%0d",
                       got.read_value, got.element_count, got.is_empty, got.status));
        return;
      end
      want = due_responses[0];
      due_responses.delete(0);
      if (got.read_value !== want.read_value || got.element_count !== want.element_count ||
          got.is_empty !== want.is_empty || got.status !== want.status)
        flag($sformatf({"expected rd=%0d cnt=%0d empty=%0b st=%0d, ",
                        "got rd=%0d cnt=%0d empty=%0b st=%0d"},
                       want.read_value, want.element_count, want.is_empty, want.status,
                       got.read_value, got.element_count, got.is_empty, got.status));
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      start_i;
  logic      busy_o;
  idel_req_t req_i;
  logic      done_o;
  idel_res_t res_o;

  list_tracker tracker;
  int unsigned cycle_count = 0;

  indexed_double_ended_list dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .req_i  (req_i),
    .done_o (done_o),
    .res_o  (res_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && tracker != null) begin
      if (start_i && !busy_o) tracker.note_request(req_i);
      if (done_o) tracker.check_result(res_o);
    end
  end

  function automatic idel_req_t req_of(logic [3:0] kind, int unsigned pos,
                                       logic [31:0] val);
    idel_req_t r;
    r.req_type   = kind;
    r.position   = pos[POS_W-1:0];
    r.item_value = val;
    return r;
  endfunction

  function automatic idel_req_t make_request(mix_e mix, int unsigned cur_count);
    int unsigned writes;
    int unsigned removes;
    int unsigned roll;
    int unsigned pick;
    logic [3:0]  kind;
    int unsigned pos;
    logic [31:0] val;
    case (mix)
      MIX_GROW:   begin writes = 60; removes = 15; end
      MIX_SHRINK: begin writes = 15; removes = 60; end
      default:    begin writes = 36; removes = 36; end
    endcase
    roll = $urandom_range(0, 99);
    pick = $urandom_range(0, 2);
    if (roll < 3)
      kind = 4'($urandom_range(int'(REQ_ERASE) + 1, 15));
    else if (roll < 3 + writes)
      kind = (pick == 0) ? REQ_PUSH_FRONT : (pick == 1) ? REQ_PUSH_BACK : REQ_INSERT;
    else if (roll < 3 + writes + removes)
      kind = (pick == 0) ? REQ_POP_FRONT : (pick == 1) ? REQ_POP_BACK : REQ_ERASE;
    else
      kind = (pick == 0) ? REQ_FRONT : (pick == 1) ? REQ_BACK : REQ_GET;
    if ($urandom_range(0, 4) != 0) pos = $urandom_range(0, cur_count);
    else pos = $urandom_range(0, 31);
    case ($urandom_range(0, 19))
      0:       val = 32'h8000_0000;
      1:       val = 32'h7fff_ffff;
      2:       val = 32'h0000_0000;
      3:       val = 32'hffff_ffff;
      default: val = $urandom();
    endcase
    return req_of(kind, pos, val);
  endfunction

  task automatic send(idel_req_t r);
    start_i <= 1'b1;
    req_i   <= r;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic pause(int unsigned cycles);
    start_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (tracker.outstanding() != 0) @(posedge clk_i);
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    mix_e mix;
    bit   gaps_on;
    tracker = new();
    rst_ni  <= 1'b0;
    start_i <= 1'b0;
    req_i   <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty list, range and unknown-request corner cases
    send(req_of(REQ_FRONT, 0, 0));
    send(req_of(REQ_BACK, 0, 0));
    send(req_of(REQ_POP_FRONT, 0, 0));
    send(req_of(REQ_POP_BACK, 0, 0));
    send(req_of(REQ_GET, 0, 0));
    send(req_of(REQ_ERASE, 0, 0));
    send(req_of(REQ_INSERT, 1, 32'h1111_1111));
    send(req_of(REQ_INSERT, 0, 32'h7fff_ffff));
    send(req_of(REQ_PUSH_FRONT, 0, 32'h8000_0000));
    send(req_of(REQ_PUSH_BACK, 0, 32'hffff_ffff));
    send(req_of(REQ_PUSH_BACK, 0, 32'h0000_0000));
    send(req_of(REQ_INSERT, 2, 32'h1234_5678));
    send(req_of(REQ_GET, 31, 0));
    send(req_of(REQ_GET, 4, 0));
    send(req_of(REQ_FRONT, 0, 0));
    send(req_of(REQ_BACK, 0, 0));
    send(req_of(REQ_ERASE, 5, 0));
    send(req_of(REQ_ERASE, 2, 0));
    send(req_of(REQ_INSERT, 31, 32'hdead_beef));
    send(req_of(4'(int'(REQ_ERASE) + 1), 7, 32'h5555_aaaa));
    send(req_of(4'hf, 31, 32'hffff_ffff));
    send(req_of(REQ_POP_FRONT, 0, 0));
    send(req_of(REQ_POP_BACK, 0, 0));
    send(req_of(REQ_GET, 1, 0));
    drain();

    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      case (ph % 3)
        0:       mix = MIX_GROW;
        1:       mix = MIX_EVEN;
        default: mix = MIX_SHRINK;
      endcase
      gaps_on = (ph != 4) && (ph != PHASES - 1);
      for (int unsigned n = 0; n < PHASE_LEN; n++) begin
        if (gaps_on && $urandom_range(0, 7) == 0) pause($urandom_range(1, 11));
        send(make_request(mix, tracker.count));
      end
      if (ph == 2) drain();
    end

    drain();
    repeat (4) @(posedge clk_i);
    if (tracker.failures == 0 && tracker.outstanding() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: indexed_double_ended_list.f
src/idel_pkg.sv
src/idel_ctrl.sv
src/idel_cells.sv
src/indexed_double_ended_list.sv
verif/testbench.sv
